// ----- rtl/core/tjp_pkg.sv -----
`timescale 1ns / 1ps

package tjp_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W  = 20;
  localparam int VEL_W  = 20;
  localparam int SPD_W  = 19;
  localparam int ACC_W  = 22;
  localparam int DT_W   = 14;
  localparam int ERR_W  = POS_W + 1;
  localparam int MUL_W  = ACC_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LHS_W  = POS_W + ACC_W + 1;
  localparam int SUM_W  = POS_W + 3;
  localparam int CFG_W  = ACC_W;
  localparam int IDX_W  = 2;
  localparam int STEP_W = 4;

  localparam int EPS_POS = ((2 ** FRAC_BITS) + 5000) / 10000;
  localparam int EPS_VEL = ((2 ** FRAC_BITS) + 500) / 1000;

  localparam logic signed [POS_W-1:0] MIN_POS_RST = POS_W'(-(2 ** (POS_W - 1)));
  localparam logic signed [POS_W-1:0] MAX_POS_RST = POS_W'((2 ** (POS_W - 1)) - 1);
  localparam logic [SPD_W-1:0]        MAX_SPD_RST = SPD_W'(65536);
  localparam logic [ACC_W-1:0]        MAX_ACC_RST = ACC_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    CFG_MIN_POS = 2'd0,
    CFG_MAX_POS = 2'd1,
    CFG_MAX_SPD = 2'd2,
    CFG_MAX_ACC = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CLAMP,
    ACT_ERR,
    ACT_SETTLE,
    ACT_LHS,
    ACT_DECIDE,
    ACT_VEL,
    ACT_POS,
    ACT_SNAP,
    ACT_OUT
  } act_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DIST_ACC,
    MUL_ALONG_SQ,
    MUL_ACC_DT,
    MUL_VEL_DT
  } mul_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_IN_VALID,
    CND_PRESET,
    CND_SETTLED,
    CND_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e              act;
    mul_e              mul;
    cond_e             cond;
    logic              stay;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_CLAMP  = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_ERR    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_SETTLE = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_LHS    = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_DECIDE = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_ACCDT  = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_VEL    = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_VELDT  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_POS    = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_SNAP   = STEP_W'(10);
  localparam logic [STEP_W-1:0] ST_FINISH = STEP_W'(11);

  // microprogram: jump to target when the condition holds, else stay or step on
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{act: ACT_NONE, mul: MUL_NONE, cond: CND_ALWAYS, stay: 1'b0, target: ST_IDLE};
    case (step)
      ST_IDLE:   w = '{act: ACT_LOAD,   mul: MUL_NONE,     cond: CND_IN_VALID,
                       stay: 1'b1, target: ST_CLAMP};
      ST_CLAMP:  w = '{act: ACT_CLAMP,  mul: MUL_NONE,     cond: CND_PRESET,
                       stay: 1'b0, target: ST_FINISH};
      ST_ERR:    w = '{act: ACT_ERR,    mul: MUL_NONE,     cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_SETTLE: w = '{act: ACT_SETTLE, mul: MUL_DIST_ACC, cond: CND_SETTLED,
                       stay: 1'b0, target: ST_FINISH};
      ST_LHS:    w = '{act: ACT_LHS,    mul: MUL_ALONG_SQ, cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_DECIDE: w = '{act: ACT_DECIDE, mul: MUL_NONE,     cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_ACCDT:  w = '{act: ACT_NONE,   mul: MUL_ACC_DT,   cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_VEL:    w = '{act: ACT_VEL,    mul: MUL_NONE,     cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_VELDT:  w = '{act: ACT_NONE,   mul: MUL_VEL_DT,   cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_POS:    w = '{act: ACT_POS,    mul: MUL_NONE,     cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_SNAP:   w = '{act: ACT_SNAP,   mul: MUL_NONE,     cond: CND_NEVER,
                       stay: 1'b0, target: ST_IDLE};
      ST_FINISH: w = '{act: ACT_OUT,    mul: MUL_NONE,     cond: CND_OUT_FREE,
                       stay: 1'b1, target: ST_IDLE};
      default:   w = '{act: ACT_NONE,   mul: MUL_NONE,     cond: CND_ALWAYS,
                       stay: 1'b0, target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/trapezoidal_joint_profile_core.sv -----
// sequence: a tick steps from clamp to finish, a settled tick jumps there from settle, a preset from clamp
// input is taken only in the idle step, so a new word waits until the microcode step counter that
// walks the shared 22x22 multiplier through up to four products per tick has returned to idle
// reset: asynchronous active low, clears position and velocity to zero, loads register defaults
// and returns the sequencer to its idle step with no result pending
`timescale 1ns / 1ps

module trapezoidal_joint_profile_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tjp_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [tjp_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic signed [tjp_pkg::POS_W-1:0]     target_position_i,
  input  logic [tjp_pkg::DT_W-1:0]             tick_period_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tjp_pkg::POS_W-1:0]     command_position_o,
  output logic signed [tjp_pkg::VEL_W-1:0]     command_velocity_o,
  output logic                                 at_target_o
);
  import tjp_pkg::*;

  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(MAX_POS_RST);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(MIN_POS_RST);

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             ctrl;
  logic              cond_hit;
  logic              in_accept;

  logic signed [POS_W-1:0] min_pos_q, max_pos_q;
  logic [SPD_W-1:0]        max_spd_q;
  logic [ACC_W-1:0]        max_acc_q;

  logic                    opcode_q;
  logic signed [POS_W-1:0] tgt_q;
  logic [DT_W-1:0]         dt_q;
  logic signed [POS_W-1:0] pos_q;
  logic signed [VEL_W-1:0] vel_q;
  logic signed [ERR_W-1:0] err_q;
  logic signed [POS_W-1:0] qn_q;
  logic [PROD_W-1:0]       prod_q;
  logic [LHS_W-1:0]        lhs_q;
  logic                    acc_en_q, acc_neg_q;
  logic                    snap_q;

  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic signed [VEL_W-1:0] out_vel_q;
  logic                    out_snap_q;

  logic [ERR_W-1:0]        err_abs;
  logic [POS_W-1:0]        dist_mag;
  logic [VEL_W-1:0]        vel_abs_w;
  logic [SPD_W-1:0]        vel_abs;
  logic signed [ERR_W-1:0] along;
  logic                    settled;
  logic                    brake;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       prod_rnd, prod_sh;
  logic signed [SUM_W-1:0] delta, vsum, spd, vclamp, qsum, qsat;
  logic signed [POS_W-1:0] tgt_clamped;
  logic signed [ERR_W-1:0] e_new;
  logic                    snap_hit;

  assign ctrl      = ucode_rom(step_q);
  assign in_ready_o = (step_q == ST_IDLE);
  assign in_accept = in_valid_i && in_ready_o;

  assign err_abs   = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign dist_mag  = err_abs[POS_W-1:0];
  assign vel_abs_w = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
  assign vel_abs   = vel_abs_w[SPD_W-1:0];
  assign along     = err_q[ERR_W-1] ? -ERR_W'(vel_q) : ERR_W'(vel_q);
  assign settled   = (err_abs < ERR_W'(EPS_POS)) && (vel_abs_w < VEL_W'(EPS_VEL));
  assign brake     = (along > 0) && ({1'b0, lhs_q} <= prod_q);

  always_comb begin
    case (ctrl.cond)
      CND_NEVER:    cond_hit = 1'b0;
      CND_ALWAYS:   cond_hit = 1'b1;
      CND_IN_VALID: cond_hit = in_valid_i;
      CND_PRESET:   cond_hit = opcode_q;
      CND_SETTLED:  cond_hit = settled;
      CND_OUT_FREE: cond_hit = !out_valid_q || out_ready_i;
      default:      cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_d = ctrl.target;
    end else if (ctrl.stay) begin
      step_d = step_q;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (ctrl.mul)
      MUL_DIST_ACC: begin
        mul_a = MUL_W'(dist_mag);
        mul_b = max_acc_q;
      end
      MUL_ALONG_SQ: begin
        mul_a = MUL_W'(vel_abs);
        mul_b = MUL_W'(vel_abs);
      end
      MUL_ACC_DT: begin
        mul_a = max_acc_q;
        mul_b = MUL_W'(dt_q);
      end
      MUL_VEL_DT: begin
        mul_a = MUL_W'(vel_abs);
        mul_b = MUL_W'(dt_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounded product, ties away from zero on the magnitude
  always_comb begin
    prod_rnd = prod_q + HALF_LSB;
    prod_sh  = prod_rnd >> FRAC_BITS;
    delta    = $signed({1'b0, prod_sh[SUM_W-2:0]});
    spd      = $signed(SUM_W'(max_spd_q));

    if (!acc_en_q) begin
      vsum = SUM_W'(vel_q);
    end else if (acc_neg_q) begin
      vsum = SUM_W'(vel_q) - delta;
    end else begin
      vsum = SUM_W'(vel_q) + delta;
    end
    if (vsum > spd) begin
      vclamp = spd;
    end else if (vsum < -spd) begin
      vclamp = -spd;
    end else begin
      vclamp = vsum;
    end

    if (vel_q[VEL_W-1]) begin
      qsum = SUM_W'(pos_q) - delta;
    end else begin
      qsum = SUM_W'(pos_q) + delta;
    end
    if (qsum > SAT_HI) begin
      qsat = SAT_HI;
    end else if (qsum < SAT_LO) begin
      qsat = SAT_LO;
    end else begin
      qsat = qsum;
    end

    if (tgt_q < min_pos_q) begin
      tgt_clamped = min_pos_q;
    end else if (tgt_q > max_pos_q) begin
      tgt_clamped = max_pos_q;
    end else begin
      tgt_clamped = tgt_q;
    end

    e_new    = ERR_W'(tgt_q) - ERR_W'(qn_q);
    snap_hit = (err_q == '0) || (e_new == '0) || (err_q[ERR_W-1] != e_new[ERR_W-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      min_pos_q   <= MIN_POS_RST;
      max_pos_q   <= MAX_POS_RST;
      max_spd_q   <= MAX_SPD_RST;
      max_acc_q   <= MAX_ACC_RST;
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_POS: min_pos_q <= $signed(cfg_data_i[POS_W-1:0]);
          CFG_MAX_POS: max_pos_q <= $signed(cfg_data_i[POS_W-1:0]);
          CFG_MAX_SPD: max_spd_q <= cfg_data_i[SPD_W-1:0];
          CFG_MAX_ACC: max_acc_q <= cfg_data_i[ACC_W-1:0];
          default: ;
        endcase
      end

      if (ctrl.mul != MUL_NONE) begin
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      if ((ctrl.act == ACT_OUT) && cond_hit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (ctrl.act)
        ACT_LOAD: begin
          if (in_accept) begin
            opcode_q <= opcode_i;
            tgt_q    <= target_position_i;
            dt_q     <= tick_period_i;
          end
        end
        ACT_CLAMP: begin
          snap_q <= 1'b0;
          if (opcode_q) begin
            pos_q <= tgt_q;
            vel_q <= '0;
          end else begin
            tgt_q <= tgt_clamped;
          end
        end
        ACT_ERR: begin
          err_q <= ERR_W'(tgt_q) - ERR_W'(pos_q);
        end
        ACT_SETTLE: begin
          if (settled) begin
            pos_q  <= tgt_q;
            vel_q  <= '0;
            snap_q <= 1'b1;
          end
        end
        ACT_LHS: begin
          lhs_q <= {prod_q[LHS_W-2:0], 1'b0};
        end
        ACT_DECIDE: begin
          if (brake) begin
            acc_en_q  <= 1'b1;
            acc_neg_q <= !err_q[ERR_W-1];
          end else if (along < $signed(ERR_W'(max_spd_q))) begin
            acc_en_q  <= 1'b1;
            acc_neg_q <= err_q[ERR_W-1];
          end else begin
            acc_en_q  <= 1'b0;
            acc_neg_q <= 1'b0;
          end
        end
        ACT_VEL: begin
          vel_q <= vclamp[VEL_W-1:0];
        end
        ACT_POS: begin
          qn_q <= qsat[POS_W-1:0];
        end
        ACT_SNAP: begin
          if (snap_hit) begin
            pos_q  <= tgt_q;
            vel_q  <= '0;
            snap_q <= 1'b1;
          end else begin
            pos_q <= qn_q;
          end
        end
        ACT_OUT: begin
          if (cond_hit) begin
            out_pos_q   <= pos_q;
            out_vel_q   <= vel_q;
            out_snap_q  <= snap_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign command_position_o = out_pos_q;
  assign command_velocity_o = out_vel_q;
  assign at_target_o        = out_snap_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tjp_pkg::*;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam int PHASE_ITEMS  = 97;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD    = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 24;

  localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));
  localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint SETTLE_POS_LIM = ((longint'(1) <<< FRAC_BITS) + 5000) / 10000;
  localparam longint SETTLE_VEL_LIM = ((longint'(1) <<< FRAC_BITS) + 500) / 1000;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] target;
    logic [DT_W-1:0]  period;
  } move_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
    logic             at_tgt;
  } cmd_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             cfg_we   = 1'b0;
  cfg_idx_e         cfg_idx  = CFG_MIN_POS;
  logic [CFG_W-1:0] cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             opcode   = OP_TICK;
  logic [POS_W-1:0] target   = '0;
  logic [DT_W-1:0]  period   = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [POS_W-1:0] cmd_pos;
  logic [VEL_W-1:0] cmd_vel;
  logic             at_tgt;

  trapezoidal_joint_profile_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .opcode_i           (opcode),
    .target_position_i  (target),
    .tick_period_i      (period),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .command_position_o (cmd_pos),
    .command_velocity_o (cmd_vel),
    .at_target_o        (at_tgt)
  );

  // joint limits and profile state as the block should hold them
  longint lim_lo  = POS_LO;
  longint lim_hi  = POS_HI;
  longint spd_lim = 65536;
  longint acc_lim = 65536;
  longint pos_q   = 0;
  longint vel_q   = 0;

  move_word_t move_queue[$];
  cmd_word_t  cmd_expect[$];
  move_word_t offered;
  cmd_word_t  exp_word;

  logic quiet = 1'b0;
  int   n_errors = 0;
  int   n_results = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  bit   long_hold_done = 1'b0;
  int   stuck_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // a * dt / 2^FRAC_BITS, rounded half away from zero
  function automatic longint scale_by_tick(longint a, longint dt);
    longint p;
    p = (mag(a) * dt + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (a < 0) ? -p : p;
  endfunction

  function automatic cmd_word_t advance_profile(move_word_t w);
    longint tgt, dt, q, v, err, dir, dist_mag, along, acc, q_nxt, e_nxt;
    logic snap;
    cmd_word_t r;
    tgt  = $signed(w.target);
    dt   = longint'(w.period);
    snap = 1'b0;
    if (w.opcode == OP_PRESET) begin
      pos_q = tgt;
      vel_q = 0;
    end else begin
      q = pos_q;
      v = vel_q;
      if (tgt < lim_lo) begin
        tgt = lim_lo;
      end else if (tgt > lim_hi) begin
        tgt = lim_hi;
      end
      err = tgt - q;
      if (mag(err) < SETTLE_POS_LIM && mag(v) < SETTLE_VEL_LIM) begin
        pos_q = tgt;
        vel_q = 0;
        snap  = 1'b1;
      end else begin
        dir      = (err >= 0) ? 1 : -1;
        dist_mag = mag(err);
        along    = v * dir;
        acc      = 0;
        if (along > 0 && dist_mag * 2 * acc_lim <= along * along) begin
          acc = -dir * acc_lim;
        end else if (along < spd_lim) begin
          acc = dir * acc_lim;
        end
        v = v + scale_by_tick(acc, dt);
        if (v > spd_lim) v = spd_lim;
        if (v < -spd_lim) v = -spd_lim;
        q_nxt = q + scale_by_tick(v, dt);
        if (q_nxt > POS_HI) q_nxt = POS_HI;
        if (q_nxt < POS_LO) q_nxt = POS_LO;
        e_nxt = tgt - q_nxt;
        // overshoot, landing exactly or starting on the target snaps onto the target
        if (err == 0 || e_nxt == 0 || ((err < 0) != (e_nxt < 0))) begin
          q_nxt = tgt;
          v     = 0;
          snap  = 1'b1;
        end
        pos_q = q_nxt;
        vel_q = v;
      end
    end
    r.pos    = POS_W'(pos_q);
    r.vel    = VEL_W'(vel_q);
    r.at_tgt = snap;
    return r;
  endfunction

  function automatic int rand_position();
    return int'($signed(POS_W'($urandom)));
  endfunction

  task automatic queue_move(input logic op, input int tgt, input int dt);
    move_queue.push_back('{opcode: op, target: POS_W'(tgt), period: DT_W'(dt)});
  endtask

  // called right after a rising edge while the block is idle
  task automatic load_limits(input int lo, input int hi, input int spd, input int acc);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MIN_POS;
    cfg_data <= CFG_W'(lo);
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_POS;
    cfg_data <= CFG_W'(hi);
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_SPD;
    cfg_data <= CFG_W'(spd);
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_ACC;
    cfg_data <= CFG_W'(acc);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    lim_lo  = lo;
    lim_hi  = hi;
    spd_lim = spd;
    acc_lim = acc;
  endtask

  task automatic drain();
    while (move_queue.size() != 0 || in_valid || cmd_expect.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // mostly runs of ticks toward one target, with presets and odd ticks mixed in
  task automatic queue_profile_run(input int count);
    int pushed, run_len, aim, pick, k, dt;
    pushed = 0;
    aim    = 0;
    while (pushed < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_move(OP_PRESET, rand_position(), $urandom_range(0, 16383));
        pushed++;
      end else if (pick == 1) begin
        queue_move(OP_TICK, rand_position(), $urandom_range(0, 16383));
        pushed++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          aim = rand_position();
        end else begin
          aim = aim + int'($urandom_range(0, 300000)) - 150000;
        end
        if (aim > POS_HI) aim = POS_HI;
        if (aim < POS_LO) aim = POS_LO;
        run_len = $urandom_range(5, 40);
        for (k = 0; k < run_len && pushed < count; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            dt = $urandom_range(0, 16383);
          end else begin
            dt = $urandom_range(66, 13107);
          end
          queue_move(OP_TICK, aim, dt);
          pushed++;
        end
      end
    end
  endtask

  initial begin
    int k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, register defaults
    queue_move(OP_TICK, 0, 6554);
    queue_move(OP_TICK, 65536, 6554);
    queue_move(OP_TICK, 65536, 13107);
    queue_move(OP_TICK, 65536, 16383);
    queue_move(OP_TICK, -524288, 0);
    queue_move(OP_PRESET, 524287, 0);
    queue_move(OP_TICK, 524287, 66);
    queue_move(OP_PRESET, -524288, 16383);
    queue_move(OP_TICK, 524287, 16383);
    queue_move(OP_PRESET, 65539, 6554);
    queue_move(OP_TICK, 65536, 6554);
    queue_move(OP_PRESET, 1000, 6554);
    queue_move(OP_TICK, 1007, 6554);
    queue_move(OP_PRESET, 0, 13107);
    for (k = 0; k < 4; k++) queue_move(OP_TICK, 20000, 13107);
    queue_move(OP_PRESET, 0, 13107);
    for (k = 0; k < 2; k++) queue_move(OP_TICK, -20000, 13107);
    drain();

    load_limits(-524288, 524287, 524287, 4194303);
    queue_profile_run(PHASE_ITEMS);
    drain();

    load_limits(-300000, 300000, 65536, 131072);
    queue_profile_run(PHASE_ITEMS);
    drain();

    // inverted limits
    load_limits(100000, -100000, 30000, 1);
    queue_profile_run(PHASE_ITEMS);
    drain();

    load_limits(-524288, 524287, $urandom_range(20000, 100000), 0);
    queue_profile_run(PHASE_ITEMS);
    drain();

    load_limits(-200000, 250000, 0, 4194303);
    queue_profile_run(PHASE_ITEMS);
    drain();

    load_limits(int'($urandom_range(0, 300000)) - 524288,
                524287 - int'($urandom_range(0, 300000)),
                $urandom_range(5000, 200000), $urandom_range(1, 2000000));
    queue_profile_run(PHASE_ITEMS);
    drain();

    quiet <= 1'b1;
    load_limits(int'($urandom_range(0, 300000)) - 524288,
                524287 - int'($urandom_range(0, 300000)),
                $urandom_range(5000, 200000), $urandom_range(1, 2000000));
    queue_profile_run(PHASE_ITEMS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cmd_expect.push_back(advance_profile(offered));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (move_queue.size() != 0) begin
          offered = move_queue.pop_front();
          in_valid <= 1'b1;
          opcode   <= offered.opcode;
          target   <= offered.target;
          period   <= offered.period;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (cmd_expect.size() == 0) begin
          $display("%0t: word with nothing expected, pos %0d vel %0d at_target %0b",
                   $time, $signed(cmd_pos), $signed(cmd_vel), at_tgt);
          n_errors++;
        end else begin
          exp_word = cmd_expect.pop_front();
          if (cmd_pos !== exp_word.pos) begin
            $display("%0t: command_position expected %0d got %0d",
                     $time, $signed(exp_word.pos), $signed(cmd_pos));
            n_errors++;
          end
          if (cmd_vel !== exp_word.vel) begin
            $display("%0t: command_velocity expected %0d got %0d",
                     $time, $signed(exp_word.vel), $signed(cmd_vel));
            n_errors++;
          end
          if (at_tgt !== exp_word.at_tgt) begin
            $display("%0t: at_target expected %0b got %0b",
                     $time, exp_word.at_tgt, at_tgt);
            n_errors++;
          end
        end
        // long back-pressure so the block fills and stalls its input
        if (n_results == LONG_HOLD_AT && !long_hold_done) begin
          long_hold_done = 1'b1;
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/core/tjp_pkg.sv
rtl/core/trapezoidal_joint_profile_core.sv
tb/tb_top.sv
